// ===== rtl/lcec_pkg.sv =====
// Shared constants, types and sequencer states for the largest component edge count block.
package lcec_pkg;

	localparam int MAX_NODES = 1024;
	localparam int MAX_EDGES = 4096;
	localparam int NODE_W    = $clog2(MAX_NODES);
	localparam int EDGE_AW   = $clog2(MAX_EDGES);
	localparam int FILL_W    = EDGE_AW + 1;
	localparam int CNT_W     = NODE_W + 1;
	localparam int END_W     = 11;
	localparam int SUM_W     = 14;
	localparam int RES_W     = 13;
	localparam int PAIR_W    = 2 * NODE_W;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_LOAD,
		ST_START,
		ST_START_CHK,
		ST_POP,
		ST_POP_WAIT,
		ST_SCAN,
		ST_EDGE,
		ST_VIS,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic              hit;
		logic [NODE_W-1:0] other;
	} match_t;

endpackage

// ===== rtl/lcec_ram.sv =====
// Generic single write port, single read port RAM with registered read.
module lcec_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/lcec_match.sv =====
// Shared endpoint compare unit: tests a stored edge against the current vertex.
module lcec_match (
	input  logic [lcec_pkg::PAIR_W-1:0] pair,
	input  logic [lcec_pkg::NODE_W-1:0] vertex,
	output lcec_pkg::match_t            result
);

	logic [lcec_pkg::NODE_W-1:0] end_lo;
	logic [lcec_pkg::NODE_W-1:0] end_hi;
	logic                        hit_lo;

	assign end_lo = pair[lcec_pkg::NODE_W-1:0];
	assign end_hi = pair[lcec_pkg::PAIR_W-1:lcec_pkg::NODE_W];
	assign hit_lo = (end_lo == vertex);

	// take the far endpoint; a self-loop hands back the vertex itself
	assign result.hit   = hit_lo || (end_hi == vertex);
	assign result.other = hit_lo ? end_hi : end_lo;

endmodule

// ===== rtl/largest_component_edge_count.sv =====
// Top level: edge loader, depth first component walker and result register.
// Sequence: edge words are stored while loading; the last edge starts a depth first walk
//   from every unreached start vertex below the node count, and once the result word is
//   loaded, a pass clears the visited map.
// Throughput: one edge per cycle while loading; the walk rescans the edge RAM
//   through the shared compare unit once per popped vertex.
// Reset: arst_n clears control state, then a pass clears the visited map.
module largest_component_edge_count (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [10:0] cfg_wdata,      // node_count
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,   // end_a[10:0], end_b[21:11], zero pad
	input  logic        s_axis_tlast,   // last_edge
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // largest_edges[12:0], zero pad
	output logic [0:0]  m_axis_tuser    // overflow
);

	localparam int NW = lcec_pkg::NODE_W;

	lcec_pkg::state_t state_q, state_d;

	logic [lcec_pkg::END_W-1:0]  node_count_q;
	logic [lcec_pkg::CNT_W-1:0]  n_lim;
	logic [lcec_pkg::FILL_W-1:0] fill_q;
	logic [lcec_pkg::FILL_W-1:0] k_q;
	logic [lcec_pkg::CNT_W-1:0]  s_q;
	logic [lcec_pkg::CNT_W-1:0]  sp_q;
	logic [lcec_pkg::CNT_W-1:0]  clr_q;
	logic [NW-1:0]               v_q;
	logic [NW-1:0]               w_q;
	logic [lcec_pkg::SUM_W-1:0]  sum_q;
	logic [lcec_pkg::RES_W-1:0]  best_q;
	logic [lcec_pkg::RES_W-1:0]  half;
	logic                        drop_q;
	logic                        out_valid_q;
	logic [lcec_pkg::RES_W-1:0]  out_edges_q;
	logic                        out_ovf_q;
	logic                        out_load;

	logic [lcec_pkg::END_W-1:0]  end_a;
	logic [lcec_pkg::END_W-1:0]  end_b;
	logic                        ends_ok;
	logic                        accept;

	logic                        vis_we, vis_wdata, vis_rdata;
	logic [NW-1:0]               vis_waddr, vis_raddr;
	logic                        stk_we;
	logic [NW-1:0]               stk_waddr, stk_raddr, stk_wdata, stk_rdata;
	logic                        edg_we;
	logic [lcec_pkg::PAIR_W-1:0] edg_wdata, edg_rdata;
	lcec_pkg::match_t            match;

	assign end_a   = s_axis_tdata[10:0];
	assign end_b   = s_axis_tdata[21:11];
	assign ends_ok = (end_a != '0) && (end_a <= lcec_pkg::END_W'(lcec_pkg::MAX_NODES)) &&
	                 (end_b != '0) && (end_b <= lcec_pkg::END_W'(lcec_pkg::MAX_NODES));
	assign accept  = s_axis_tvalid && s_axis_tready;

	// load the result word once the output register is free
	assign out_load = (state_q == lcec_pkg::ST_FINISH) && (!out_valid_q || m_axis_tready);

	// saturate the vertex count to the map size
	assign n_lim = (node_count_q > lcec_pkg::END_W'(lcec_pkg::MAX_NODES)) ?
	               lcec_pkg::CNT_W'(lcec_pkg::MAX_NODES) : lcec_pkg::CNT_W'(node_count_q);
	assign half  = sum_q[lcec_pkg::SUM_W-1:1];

	// endpoints go in zero based, end_a in the low half
	assign edg_we    = accept && ends_ok && (fill_q < lcec_pkg::FILL_W'(lcec_pkg::MAX_EDGES));
	assign edg_wdata = {NW'(end_b - 11'd1), NW'(end_a - 11'd1)};

	lcec_ram #(.WIDTH(lcec_pkg::PAIR_W), .DEPTH(lcec_pkg::MAX_EDGES)) u_edges (
		.clk   (clk),
		.we    (edg_we),
		.waddr (fill_q[lcec_pkg::EDGE_AW-1:0]),
		.wdata (edg_wdata),
		.raddr (k_q[lcec_pkg::EDGE_AW-1:0]),
		.rdata (edg_rdata)
	);

	lcec_ram #(.WIDTH(1), .DEPTH(lcec_pkg::MAX_NODES)) u_visited (
		.clk   (clk),
		.we    (vis_we),
		.waddr (vis_waddr),
		.wdata (vis_wdata),
		.raddr (vis_raddr),
		.rdata (vis_rdata)
	);

	lcec_ram #(.WIDTH(NW), .DEPTH(lcec_pkg::MAX_NODES)) u_stack (
		.clk   (clk),
		.we    (stk_we),
		.waddr (stk_waddr),
		.wdata (stk_wdata),
		.raddr (stk_raddr),
		.rdata (stk_rdata)
	);

	lcec_match u_match (
		.pair   (edg_rdata),
		.vertex (v_q),
		.result (match)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lcec_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		s_axis_tready = 1'b0;
		vis_we        = 1'b0;
		vis_waddr     = clr_q[NW-1:0];
		vis_wdata     = 1'b0;
		vis_raddr     = s_q[NW-1:0];
		stk_we        = 1'b0;
		stk_waddr     = sp_q[NW-1:0];
		stk_wdata     = w_q;
		stk_raddr     = NW'(sp_q - 1'b1);
		unique case (state_q)
			lcec_pkg::ST_CLEAR: begin
				vis_we = 1'b1;
				if (clr_q == lcec_pkg::CNT_W'(lcec_pkg::MAX_NODES - 1)) begin
					state_d = lcec_pkg::ST_LOAD;
				end
			end
			lcec_pkg::ST_LOAD: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid && s_axis_tlast) begin
					state_d = lcec_pkg::ST_START;
				end
			end
			lcec_pkg::ST_START: begin
				state_d = (s_q < n_lim) ? lcec_pkg::ST_START_CHK : lcec_pkg::ST_FINISH;
			end
			lcec_pkg::ST_START_CHK: begin
				// an unreached start vertex opens a new component
				if (!vis_rdata) begin
					vis_we    = 1'b1;
					vis_waddr = s_q[NW-1:0];
					vis_wdata = 1'b1;
					stk_we    = 1'b1;
					stk_wdata = s_q[NW-1:0];
					state_d   = lcec_pkg::ST_POP;
				end else begin
					state_d = lcec_pkg::ST_START;
				end
			end
			lcec_pkg::ST_POP: begin
				state_d = (sp_q == '0) ? lcec_pkg::ST_START : lcec_pkg::ST_POP_WAIT;
			end
			lcec_pkg::ST_POP_WAIT: begin
				state_d = lcec_pkg::ST_SCAN;
			end
			lcec_pkg::ST_SCAN: begin
				state_d = (k_q == fill_q) ? lcec_pkg::ST_POP : lcec_pkg::ST_EDGE;
			end
			lcec_pkg::ST_EDGE: begin
				vis_raddr = match.other;
				state_d   = match.hit ? lcec_pkg::ST_VIS : lcec_pkg::ST_SCAN;
			end
			lcec_pkg::ST_VIS: begin
				// mark and push a neighbor seen for the first time
				if (!vis_rdata) begin
					vis_we    = 1'b1;
					vis_waddr = w_q;
					vis_wdata = 1'b1;
					stk_we    = 1'b1;
				end
				state_d = lcec_pkg::ST_SCAN;
			end
			lcec_pkg::ST_FINISH: begin
				if (!out_valid_q || m_axis_tready) begin
					state_d = lcec_pkg::ST_CLEAR;
				end
			end
			default: state_d = lcec_pkg::ST_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= lcec_pkg::END_W'(1);
			fill_q       <= '0;
			k_q          <= '0;
			s_q          <= '0;
			sp_q         <= '0;
			clr_q        <= '0;
			sum_q        <= '0;
			best_q       <= '0;
			drop_q       <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				node_count_q <= cfg_wdata;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tvalid && m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				lcec_pkg::ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
				end
				lcec_pkg::ST_LOAD: begin
					clr_q <= '0;
					s_q   <= '0;
					sp_q  <= '0;
					best_q <= '0;
					if (accept && ends_ok) begin
						if (fill_q < lcec_pkg::FILL_W'(lcec_pkg::MAX_EDGES)) begin
							fill_q <= fill_q + 1'b1;
						end else begin
							drop_q <= 1'b1;
						end
					end
				end
				lcec_pkg::ST_START_CHK: begin
					if (!vis_rdata) begin
						sp_q  <= sp_q + 1'b1;
						sum_q <= '0;
					end else begin
						s_q <= s_q + 1'b1;
					end
				end
				lcec_pkg::ST_POP: begin
					if (sp_q == '0) begin
						// component done: keep the larger half sum, advance the start
						if (half > best_q) begin
							best_q <= half;
						end
						s_q <= s_q + 1'b1;
					end else begin
						sp_q <= sp_q - 1'b1;
					end
				end
				lcec_pkg::ST_POP_WAIT: begin
					k_q <= '0;
				end
				lcec_pkg::ST_SCAN: begin
					if (k_q != fill_q) begin
						k_q <= k_q + 1'b1;
					end
				end
				lcec_pkg::ST_EDGE: begin
					if (match.hit) begin
						sum_q <= sum_q + 1'b1;
					end
				end
				lcec_pkg::ST_VIS: begin
					if (!vis_rdata) begin
						sp_q <= sp_q + 1'b1;
					end
				end
				lcec_pkg::ST_FINISH: begin
					if (out_load) begin
						fill_q <= '0;
						drop_q <= 1'b0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == lcec_pkg::ST_POP_WAIT) begin
			v_q <= stk_rdata;
		end
		if (state_q == lcec_pkg::ST_EDGE) begin
			w_q <= match.other;
		end
		if (out_load) begin
			out_edges_q <= best_q;
			out_ovf_q   <= drop_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = 16'(out_edges_q);
	assign m_axis_tuser  = out_ovf_q;

	a_ready_load: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> state_q == lcec_pkg::ST_LOAD)
		else $error("ready outside load state");
	a_stack_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= lcec_pkg::CNT_W'(lcec_pkg::MAX_NODES))
		else $error("stack pointer beyond map size");
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= lcec_pkg::FILL_W'(lcec_pkg::MAX_EDGES))
		else $error("edge fill beyond store size");
	a_finish_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == lcec_pkg::ST_FINISH && state_d == lcec_pkg::ST_CLEAR) |=> m_axis_tvalid)
		else $error("finished walk without a result");

endmodule

// ===== dv/largest_component_edge_count_tb.sv =====
// Testbench for the largest component edge count block: directed table plus random graphs.
module largest_component_edge_count_tb;

	typedef struct {
		int         node_cfg;   // -1: keep the current node count
		int         end_a;
		int         end_b;
		bit         last;
		bit         typed;      // expected result given in the row
		int         largest;
		bit         ovf;
	} stim_row_t;

	typedef struct {
		logic [lcec_pkg::RES_W-1:0] largest;
		logic                       ovf;
	} graph_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [10:0] cfg_wdata = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata = '0;
	logic        s_axis_tlast = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;
	logic [0:0]  m_axis_tuser;

	graph_result_t pending_results[$];
	int            fail_count = 0;
	longint        cycle_count = 0;
	int            long_hold = 0;

	// predictor state
	int  node_cnt = 1;
	int  stored_a[$];
	int  stored_b[$];
	bit  dropped = 1'b0;

	largest_component_edge_count dut (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Guard the whole run against a hang.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 20000000) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	// Walk every component from the started vertices and return the largest half degree sum.
	function automatic int largest_half_degree();
		bit visited[lcec_pkg::MAX_NODES];
		int deg[lcec_pkg::MAX_NODES];
		int stack[$];
		int n, s, v, w, k, sum, best;
		n = node_cnt > lcec_pkg::MAX_NODES ? lcec_pkg::MAX_NODES : node_cnt;
		best = 0;
		for (k = 0; k < stored_a.size(); k++) begin
			deg[stored_a[k]]++;
			if (stored_a[k] != stored_b[k])
				deg[stored_b[k]]++;
		end
		for (s = 0; s < n; s++) begin
			if (visited[s])
				continue;
			sum = 0;
			visited[s] = 1'b1;
			stack.insert(stack.size(), s);
			while (stack.size() > 0) begin
				v = stack.pop_back();
				sum += deg[v];
				for (k = 0; k < stored_a.size(); k++) begin
					w = -1;
					if (stored_a[k] == v)
						w = stored_b[k];
					else if (stored_b[k] == v)
						w = stored_a[k];
					if (w >= 0 && !visited[w]) begin
						visited[w] = 1'b1;
						stack.insert(stack.size(), w);
					end
				end
			end
			if (sum / 2 > best)
				best = sum / 2;
		end
		return best > 8191 ? 8191 : best;
	endfunction

	// Advance the predictor by one accepted edge word; returns 1 when a result is due.
	function automatic bit load_edge(input int a, input int b, input bit last,
			output graph_result_t res);
		if (a >= 1 && a <= lcec_pkg::MAX_NODES && b >= 1 && b <= lcec_pkg::MAX_NODES) begin
			if (stored_a.size() < lcec_pkg::MAX_EDGES) begin
				stored_a.insert(stored_a.size(), a - 1);
				stored_b.insert(stored_b.size(), b - 1);
			end else begin
				dropped = 1'b1;
			end
		end
		if (!last)
			return 1'b0;
		res.largest = largest_half_degree();
		res.ovf = dropped;
		stored_a.delete();
		stored_b.delete();
		dropped = 1'b0;
		return 1'b1;
	endfunction

	// Offer one edge word after a random gap (none when no_gap is set) and hold it until accepted.
	task automatic send_edge(input int a, input int b, input bit last, input bit typed,
			input int largest, input bit ovf, input bit no_gap);
		graph_result_t res;
		int gap;
		gap = no_gap ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			s_axis_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tdata = {2'b00, b[10:0], a[10:0]};
		s_axis_tlast = last;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		if (load_edge(a, b, last, res)) begin
			if (typed) begin
				res.largest = largest;
				res.ovf = ovf;
			end
			pending_results.insert(pending_results.size(), res);
		end
		@(negedge clk);
		s_axis_tvalid = 1'b0;
	endtask

	// Drain all results, let the walk and the visited-map clear finish, then write node_count.
	task automatic set_node_count(input int n);
		s_axis_tvalid = 1'b0;
		while (pending_results.size() > 0)
			@(negedge clk);
		repeat (1200) @(negedge clk);
		cfg_we = 1'b1;
		cfg_wdata = n[10:0];
		node_cnt = n;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// Receiver: random stall per cycle window, plus one long hold-off on request.
	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (long_hold > 0) begin
				m_axis_tready = 1'b0;
				long_hold--;
			end else begin
				stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
				m_axis_tready = 1'b0;
				repeat (stall) @(negedge clk);
				m_axis_tready = 1'b1;
				@(negedge clk);
				while (!(m_axis_tvalid && m_axis_tready) && long_hold == 0)
					@(negedge clk);
			end
		end
	end

	// Check each accepted result word against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result word: largest_edges %0d", m_axis_tdata[12:0]);
				fail_count++;
			end else begin
				if (m_axis_tdata[12:0] !== pending_results[0].largest) begin
					$error("largest_edges: expected %0d, got %0d",
						pending_results[0].largest, m_axis_tdata[12:0]);
					fail_count++;
				end
				if (m_axis_tuser[0] !== pending_results[0].ovf) begin
					$error("overflow: expected %0b, got %0b",
						pending_results[0].ovf, m_axis_tuser[0]);
					fail_count++;
				end
				void'(pending_results.pop_front());
			end
		end
	end

	stim_row_t directed[] = '{
		'{1,    1,    1,    1, 1, 0, 0},   // lone self-loop
		'{2,    1,    2,    0, 0, 0, 0},
		'{-1,   1,    2,    1, 1, 2, 0},   // parallel edges
		'{-1,   2,    2,    0, 0, 0, 0},
		'{-1,   2,    2,    0, 0, 0, 0},
		'{-1,   2,    2,    1, 1, 1, 0},   // three self-loops, odd sum
		'{0,    5,    6,    1, 1, 0, 0},   // no vertex starts a walk
		'{2,    0,    3,    0, 0, 0, 0},   // endpoint zero: ignored
		'{-1,   2047, 1,    0, 0, 0, 0},   // endpoint out of range: ignored
		'{-1,   1,    1025, 1, 1, 0, 0},
		'{2047, 1024, 1024, 1, 1, 0, 0},   // node count saturates
		'{1,    1,    5,    0, 0, 0, 0},
		'{-1,   5,    6,    0, 0, 0, 0},
		'{-1,   7,    8,    1, 1, 2, 0},   // vertices above node count
		'{1024, 1024, 1023, 0, 0, 0, 0},
		'{-1,   1,    1024, 0, 0, 0, 0},
		'{-1,   1023, 1,    1, 0, 0, 0},   // cycle through vertex 1 and the top vertices
		'{5,    1,    2,    0, 0, 0, 0},
		'{-1,   3,    4,    0, 0, 0, 0},
		'{-1,   4,    5,    0, 0, 0, 0},
		'{-1,   3,    3,    1, 0, 0, 0}
	};

	initial begin
		int items, n, edges, a, b, k, graphs;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;

		foreach (directed[i]) begin
			if (directed[i].node_cfg >= 0)
				set_node_count(directed[i].node_cfg);
			send_edge(directed[i].end_a, directed[i].end_b, directed[i].last,
				directed[i].typed, directed[i].largest, directed[i].ovf, 1'b0);
		end

		// Overfill the edge store: the extra edge is dropped and flagged.
		set_node_count(2);
		for (k = 0; k <= lcec_pkg::MAX_EDGES; k++)
			send_edge(1, 2, k == lcec_pkg::MAX_EDGES, k == lcec_pkg::MAX_EDGES,
				lcec_pkg::MAX_EDGES, 1'b1, 1'b1);

		items = 0;
		graphs = 0;
		while (items < 900) begin
			if (graphs % 4 == 0) begin
				case ($urandom_range(0, 9))
					0: n = 0;
					1: n = 1024;
					2: n = 2047;
					3: n = $urandom_range(17, 2047);
					default: n = $urandom_range(1, 16);
				endcase
				set_node_count(n);
			end
			// Hold results back once so the block fills up and stalls its input.
			if (graphs == 20)
				long_hold = 100000;
			edges = $urandom_range(1, 12);
			for (k = 0; k < edges; k++) begin
				case ($urandom_range(0, 19))
					0, 1: begin
						a = $urandom_range(0, 2047);
						b = $urandom_range(0, 2047);
					end
					2: begin
						a = $urandom_range(1, 1024);
						b = a;
					end
					default: begin
						a = $urandom_range(1, (node_cnt + 2 > 1024) ? 1024 : node_cnt + 2);
						b = $urandom_range(1, (node_cnt + 2 > 1024) ? 1024 : node_cnt + 2);
					end
				endcase
				send_edge(a, b, k == edges - 1, 1'b0, 0, 1'b0, graphs % 7 == 3);
				items++;
			end
			graphs++;
		end

		while (pending_results.size() > 0)
			@(negedge clk);
		repeat (1200) @(negedge clk);
		if (fail_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
